/* hw/rtl/pcg32_random_generator_macros.svh */
// assertion macros for the pcg32 random generator
`ifndef PCG32_RANDOM_GENERATOR_MACROS_SVH
`define PCG32_RANDOM_GENERATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define PCG32_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcg32 check failed");

// next-cycle implication, checked out of reset
`define PCG32_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcg32 check failed");

`endif

/* hw/rtl/pcg32_pkg.sv */
// package: constants, command type and output permutation of the pcg32 generator
`default_nettype none

package pcg32_pkg;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] LCG_MULT     = 64'd6364136223846793005;
    localparam logic [63:0] LCG_INC      = 64'd1442695040888963407;
    localparam logic [63:0] MIX_MULT_ONE = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MULT_TWO = 64'h94D049BB133111EB;
    localparam logic [63:0] SEED_OFFSET  = GOLDEN_GAMMA * (GOLDEN_GAMMA + 64'd1);

    localparam int unsigned MIX_SHIFT_ONE   = 30;
    localparam int unsigned MIX_SHIFT_TWO   = 27;
    localparam int unsigned MIX_SHIFT_THREE = 31;
    localparam int unsigned XSH_SHIFT       = 18;
    localparam int unsigned OUT_SHIFT       = 27;
    localparam int unsigned ROT_POS         = 59;

    localparam logic ACTION_SEED = 1'b0;
    localparam logic ACTION_DRAW = 1'b1;

    typedef logic [1:0] phase_t;
    localparam phase_t PHASE_NONE = 2'd0;
    localparam phase_t PHASE_LL   = 2'd1;
    localparam phase_t PHASE_LH   = 2'd2;
    localparam phase_t PHASE_HL   = 2'd3;

    typedef logic [1:0] round_t;
    localparam round_t ROUND_MIX1 = 2'd0;
    localparam round_t ROUND_MIX2 = 2'd1;
    localparam round_t ROUND_STEP = 2'd2;

    typedef struct packed {
        logic   accept;
        logic   action;
        phase_t phase;
        round_t round;
        logic   finish;
    } pcg32_cmd_t;

    function automatic logic [31:0] xsh_rr(input logic [63:0] s);
        logic [63:0] xs;
        logic [31:0] x;
        logic [4:0]  r;
        logic [63:0] dbl;
        xs  = (s ^ (s >> XSH_SHIFT)) >> OUT_SHIFT;
        x   = xs[31:0];
        r   = s[ROT_POS +: 5];
        dbl = {x, x} >> r;
        return dbl[31:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/pcg32_random_generator.sv */
// top level of the pcg32 xsh-rr random generator
//
// requests arrive on in_valid/in_ready with action, seed_value and stream_value;
// results leave on out_valid/out_ready as random_word, one per request, in order.
// action 1 draws: the word comes from the current state, which then advances
// through one 64-bit multiply-add (state * mult + inc).
// action 0 seeds: the stream is hashed by a splitmix64 finalizer, the seed is
// added, the state is loaded and advanced once; the word is zero.
// the 64-bit multiplies share one 32x32 multiplier, three partial products per
// multiply, so a draw runs one multiply and a seed runs three, one after another.
// the result is registered at request acceptance: out_valid rises in the next cycle.
// a waiting result does not block the running multiply; the next request is taken
// once the sequencer is idle and the output register is free or being read.
// reset clears the state to zero and drops out_valid.
`default_nettype none

module pcg32_random_generator (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           action,
    input  wire logic [63:0]    seed_value,
    input  wire logic [63:0]    stream_value,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [31:0]         random_word
);
    import pcg32_pkg::*;

`include "pcg32_random_generator_macros.svh"

    pcg32_cmd_t cmd;
    logic       seed_accept;

    assign seed_accept = in_valid && in_ready && (action == ACTION_SEED);

    pcg32_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    pcg32_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .seed_value   (seed_value),
        .stream_value (stream_value),
        .random_word  (random_word)
    );

    `PCG32_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_valid && in_ready, out_valid)
    `PCG32_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `PCG32_ASSERT_NEXT(a_seed_returns_zero, clk, rst_n, seed_accept, random_word == 32'd0)
    `PCG32_ASSERT_NOW(a_ready_needs_free_output, clk, rst_n, in_ready && out_valid, out_ready)

endmodule

`default_nettype wire

/* hw/rtl/pcg32_ctrl.sv */
// controller: request handshake, multiply sequencing and round order
`default_nettype none

module pcg32_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   action,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output pcg32_pkg::pcg32_cmd_t       cmd
);
    import pcg32_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL0 = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;
    round_t     round_reg, round_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.accept = accept;
        cmd.action = action;
        cmd.round  = round_reg;
        cmd.phase  = PHASE_NONE;
        cmd.finish = 1'b0;
        state_next = state_reg;
        round_next = round_reg;
        out_valid_next = accept ? 1'b1 : (out_valid_reg && !out_ready);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL0;
                    round_next = (action == ACTION_DRAW) ? ROUND_STEP : ROUND_MIX1;
                end
            end
            ST_MUL0:
            begin
                cmd.phase  = PHASE_LL;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.phase  = PHASE_LH;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.phase  = PHASE_HL;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                if (round_reg == ROUND_STEP)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MUL0;
                    round_next = round_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= ROUND_MIX1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pcg32_datapath.sv */
// datapath: generator state, shared 32x32 multiplier, mixing and output register
`default_nettype none

module pcg32_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pcg32_pkg::pcg32_cmd_t  cmd,
    input  wire logic [63:0]            seed_value,
    input  wire logic [63:0]            stream_value,
    output logic [31:0]                 random_word
);
    import pcg32_pkg::*;

    logic [63:0] state_reg, state_next;
    logic [63:0] opa_reg, opa_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] seed_reg, seed_next;
    logic [31:0] word_reg, word_next;
    logic [63:0] mult_b;
    logic [31:0] mul_x, mul_y;
    logic [63:0] prod;
    logic [63:0] z0;

    always_comb
    begin
        unique case (cmd.round)
            ROUND_MIX1: mult_b = MIX_MULT_ONE;
            ROUND_MIX2: mult_b = MIX_MULT_TWO;
            default:    mult_b = LCG_MULT;
        endcase
    end

    always_comb
    begin
        unique case (cmd.phase)
            PHASE_LH:
            begin
                mul_x = opa_reg[31:0];
                mul_y = mult_b[63:32];
            end
            PHASE_HL:
            begin
                mul_x = opa_reg[63:32];
                mul_y = mult_b[31:0];
            end
            default:
            begin
                mul_x = opa_reg[31:0];
                mul_y = mult_b[31:0];
            end
        endcase
    end

    assign prod = 64'(mul_x) * 64'(mul_y);
    assign z0   = stream_value + SEED_OFFSET;

    always_comb
    begin
        state_next = state_reg;
        opa_next   = opa_reg;
        acc_next   = acc_reg;
        seed_next  = seed_reg;
        word_next  = word_reg;
        if (cmd.accept)
        begin
            seed_next = seed_value;
            if (cmd.action == ACTION_DRAW)
            begin
                opa_next  = state_reg;
                word_next = xsh_rr(state_reg);
            end
            else
            begin
                opa_next  = z0 ^ (z0 >> MIX_SHIFT_ONE);
                word_next = 32'd0;
            end
        end
        unique case (cmd.phase)
            PHASE_LL:   acc_next = prod;
            PHASE_LH,
            PHASE_HL:   acc_next = acc_reg + {prod[31:0], 32'd0};
            default:    acc_next = acc_reg;
        endcase
        if (cmd.finish)
        begin
            unique case (cmd.round)
                ROUND_MIX1: opa_next   = acc_reg ^ (acc_reg >> MIX_SHIFT_TWO);
                ROUND_MIX2: opa_next   = seed_reg + (acc_reg ^ (acc_reg >> MIX_SHIFT_THREE));
                default:    state_next = acc_reg + LCG_INC;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= 64'd0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg  <= opa_next;
        acc_reg  <= acc_next;
        seed_reg <= seed_next;
        word_reg <= word_next;
    end

    assign random_word = word_reg;

endmodule

`default_nettype wire

/* dv/pcg32_random_generator_test.sv */
// testbench for pcg32_random_generator: seed and draw requests checked against predicted words
`timescale 1ns / 1ps

module pcg32_random_generator_test;
    import pcg32_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 20;

    class word_ledger;
        logic [63:0] gen_state;
        logic [31:0] expected_words[$];
        int unsigned fail_count;

        function new();
            gen_state = 64'd0;
            fail_count = 0;
        endfunction

        function logic [63:0] stream_hash(input logic [63:0] stream);
            logic [63:0] z;
            z = stream + SEED_OFFSET;
            z = (z ^ (z >> 30)) * MIX_MULT_ONE;
            z = (z ^ (z >> 27)) * MIX_MULT_TWO;
            return z ^ (z >> 31);
        endfunction

        function logic [31:0] step_state();
            logic [63:0] prior;
            logic [31:0] x;
            logic [4:0] r;
            prior = gen_state;
            gen_state = prior * LCG_MULT + LCG_INC;
            x = 32'((prior ^ (prior >> 18)) >> 27);
            r = prior[63:59];
            return (x >> r) | (x << (6'd32 - r));
        endfunction

        function void note_request(input logic act, input logic [63:0] seed,
                                   input logic [63:0] stream);
            logic [31:0] word;
            if (act == ACTION_SEED)
            begin
                gen_state = seed + stream_hash(stream);
                void'(step_state());
                word = 32'd0;
            end
            else
                word = step_state();
            expected_words.push_back(word);
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction

        task report_mismatch(input string what, input logic [31:0] got,
                             input logic [31:0] want);
            $display("mismatch: %s got %h want %h at %0t", what, got, want, $realtime);
            fail_count++;
        endtask

        task check_word(input logic [31:0] word);
            logic [31:0] want;
            if (expected_words.size() == 0)
                report_mismatch("random_word with no request outstanding", word, 32'd0);
            else
            begin
                want = expected_words.pop_front();
                if (word !== want)
                    report_mismatch("random_word", word, want);
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic action;
    logic [63:0] seed_value;
    logic [63:0] stream_value;
    logic out_valid;
    logic out_ready;
    logic [31:0] random_word;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned cycle_count = 0;

    word_ledger book = new();

    pcg32_random_generator dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .seed_value(seed_value),
        .stream_value(stream_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .random_word(random_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_request(input logic act, input logic [63:0] seed,
                                input logic [63:0] stream);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        seed_value <= seed;
        stream_value <= stream;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        book.note_request(act, seed, stream);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(7))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_random(input int unsigned count);
        logic act;
        for (int unsigned i = 0; i < count; i++)
        begin
            act = ($urandom_range(9) == 0) ? ACTION_SEED : ACTION_DRAW;
            send_request(act, pick_value(), pick_value());
        end
    endtask

    // receiver side
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge clk);
            if (out_valid && out_ready)
                book.check_word(random_word);
        end
    end

    initial
    begin
        logic [63:0] inv;
        logic [63:0] targets[3];
        logic [63:0] stream;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        action <= ACTION_DRAW;
        seed_value <= 64'd0;
        stream_value <= 64'd0;
        send_idle_pct = 31;
        recv_idle_pct = 53;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // draws from the reset state, payload ignored, then seeds and draws with corner payloads
        send_request(ACTION_DRAW, '1, '1);
        send_request(ACTION_DRAW, 64'd0, 64'd0);
        send_request(ACTION_SEED, 64'd0, 64'd0);
        send_request(ACTION_DRAW, 64'd0, '1);
        send_request(ACTION_SEED, '1, '1);
        send_request(ACTION_DRAW, '1, 64'd0);
        send_request(ACTION_SEED, 64'd0, '1);
        send_request(ACTION_SEED, '1, 64'd0);
        send_request(ACTION_DRAW, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(ACTION_SEED, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(ACTION_DRAW, 64'd0, 64'd0);
        send_request(ACTION_SEED, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_request(ACTION_DRAW, 64'd0, 64'd0);

        // seeds chosen so the draw sees zero rotation or the largest rotation
        inv = LCG_MULT;
        repeat (5) inv = inv * (64'd2 - LCG_MULT * inv);
        targets[0] = 64'd0;
        targets[1] = 64'h07FF_FFFF_FFFF_FFFF;
        targets[2] = 64'hF800_0000_1234_5678;
        foreach (targets[k])
        begin
            stream = {$urandom, $urandom};
            send_request(ACTION_SEED,
                         (targets[k] - LCG_INC) * inv - book.stream_hash(stream), stream);
            send_request(ACTION_DRAW, pick_value(), pick_value());
            send_request(ACTION_DRAW, pick_value(), pick_value());
        end

        send_random(450);
        wait_drained();

        send_idle_pct = 53;
        recv_idle_pct = 31;
        send_random(460);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(470);
        wait_drained();

        if (book.fail_count == 0 && book.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
